@@ sv/clns_pkg.sv @@
package clns_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned HOLD_W      = 17;

   localparam logic [7:0] NIBBLE_LO_MASK = 8'h0F;
   localparam logic [7:0] NIBBLE_HI_MASK = 8'hF0;
   localparam logic [7:0] ADDR_ROW1      = 8'h40;
   localparam logic [7:0] ADDR_SET       = 8'h80;
   localparam logic [7:0] INIT_FOURBIT   = 8'h02;
   localparam logic [7:0] INIT_FUNCSET   = 8'h28;
   localparam logic [7:0] INIT_DISPON    = 8'h0C;
   localparam logic [7:0] CLEAR_CODE     = 8'h01;

   localparam logic [7:0]  ENABLE_HIGH_RST = 8'd1;
   localparam logic [9:0]  ENABLE_LOW_RST  = 10'd100;
   localparam logic [15:0] CLEAR_WAIT_RST  = 16'd2000;
   localparam logic [15:0] SETUP_WAIT_RST  = 16'd5000;
   localparam logic [15:0] POWERUP_RST     = 16'd20000;

   typedef enum logic [2:0] {
      CMD_COMMAND = 3'd0,
      CMD_DATA    = 3'd1,
      CMD_CURSOR  = 3'd2,
      CMD_CLEAR   = 3'd3,
      CMD_INIT    = 3'd4
   } req_cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE_HIGH = 3'd0,
      CSR_ENABLE_LOW  = 3'd1,
      CSR_CLEAR_WAIT  = 3'd2,
      CSR_SETUP_WAIT  = 3'd3,
      CSR_POWERUP     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PWR,
      ST_BYTE
   } clns_state_type;

   // 4 events per byte, 4 bytes in the init sequence
   localparam logic [1:0] PHASE_LAST = 2'd3;
   localparam logic [1:0] IDX_LAST   = 2'd3;

   typedef struct packed {
      logic       load;
      logic       emit;
      logic       pwr;
      logic       last;
      logic [1:0] phase;
      logic [1:0] byte_idx;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_sts_type;

   function automatic logic [7:0] init_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = INIT_FOURBIT;
         2'd1:    b = INIT_FUNCSET;
         2'd2:    b = INIT_DISPON;
         default: b = CLEAR_CODE;
      endcase
      return b;
   endfunction

endpackage

@@ sv/clns_ctrl.sv @@
module clns_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_cmd,
   output logic                 req_stall,
   input  clns_pkg::dp_sts_type sts,
   output clns_pkg::ctl_cmd_type cmd
);

   clns_pkg::clns_state_type state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] idx_ff, idx_in;
   logic       init_ff, init_in;
   logic       active;
   logic       emit;
   logic       last;

   assign active = (state_ff != clns_pkg::ST_IDLE);
   assign emit   = active && sts.out_free;
   assign last   = (state_ff == clns_pkg::ST_BYTE) && (phase_ff == clns_pkg::PHASE_LAST)
                   && (!init_ff || (idx_ff == clns_pkg::IDX_LAST));

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      init_in  = init_ff;
      unique case (state_ff)
         clns_pkg::ST_IDLE: begin
            phase_in = 2'd0;
            idx_in   = 2'd0;
            if (req_valid) begin
               if (req_cmd == clns_pkg::CMD_INIT) begin
                  state_in = clns_pkg::ST_PWR;
                  init_in  = 1'b1;
               end else if (req_cmd <= clns_pkg::CMD_CLEAR) begin
                  state_in = clns_pkg::ST_BYTE;
                  init_in  = 1'b0;
               end
            end
         end
         clns_pkg::ST_PWR: begin
            if (emit) begin
               state_in = clns_pkg::ST_BYTE;
            end
         end
         clns_pkg::ST_BYTE: begin
            if (emit) begin
               phase_in = phase_ff + 2'd1;
               if (phase_ff == clns_pkg::PHASE_LAST) begin
                  if (last) begin
                     state_in = clns_pkg::ST_IDLE;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
            end
         end
         default: begin
            state_in = clns_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = active;
      cmd.load     = !active && req_valid;
      cmd.emit     = emit;
      cmd.pwr      = (state_ff == clns_pkg::ST_PWR);
      cmd.last     = last;
      cmd.phase    = phase_ff;
      cmd.byte_idx = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clns_pkg::ST_IDLE;
         phase_ff <= 2'd0;
         idx_ff   <= 2'd0;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         init_ff  <= init_in;
      end
   end

endmodule

@@ sv/clns_dp.sv @@
module clns_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [clns_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [clns_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [2:0]                           req_cmd,
   input  logic [7:0]                           req_value,
   input  logic [1:0]                           req_row,
   input  logic [5:0]                           req_col,
   input  clns_pkg::ctl_cmd_type                cmd,
   output clns_pkg::dp_sts_type                 sts,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [3:0]                           rsp_nibble,
   output logic                                 rsp_reg_select,
   output logic                                 rsp_enable,
   output logic [clns_pkg::HOLD_W-1:0]          rsp_hold_us,
   output logic                                 rsp_last
);

   logic [7:0]  en_high_ff;
   logic [9:0]  en_low_ff;
   logic [15:0] clear_wait_ff;
   logic [15:0] setup_wait_ff;
   logic [15:0] powerup_ff;

   logic [2:0] cmd_ff;
   logic [7:0] value_ff;
   logic [1:0] row_ff;
   logic [5:0] col_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [3:0]                  nibble_ff, nibble_in;
   logic                        rs_ff, rs_in;
   logic                        en_ff, en_in;
   logic [clns_pkg::HOLD_W-1:0] hold_ff, hold_in;
   logic                        last_ff, last_in;

   logic [7:0]  addr;
   logic [7:0]  cur_byte;
   logic [15:0] extra;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_high_ff    <= clns_pkg::ENABLE_HIGH_RST;
         en_low_ff     <= clns_pkg::ENABLE_LOW_RST;
         clear_wait_ff <= clns_pkg::CLEAR_WAIT_RST;
         setup_wait_ff <= clns_pkg::SETUP_WAIT_RST;
         powerup_ff    <= clns_pkg::POWERUP_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            clns_pkg::CSR_ENABLE_HIGH: en_high_ff    <= csr_wdata[7:0];
            clns_pkg::CSR_ENABLE_LOW:  en_low_ff     <= csr_wdata[9:0];
            clns_pkg::CSR_CLEAR_WAIT:  clear_wait_ff <= csr_wdata;
            clns_pkg::CSR_SETUP_WAIT:  setup_wait_ff <= csr_wdata;
            clns_pkg::CSR_POWERUP:     powerup_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
         row_ff   <= req_row;
         col_ff   <= req_col;
      end
   end

   assign addr = ((row_ff == 2'd1) ? clns_pkg::ADDR_ROW1 : 8'h00) + {2'b00, col_ff};

   always_comb begin
      cur_byte = value_ff;
      extra    = 16'd0;
      unique case (cmd_ff)
         clns_pkg::CMD_CURSOR: cur_byte = clns_pkg::ADDR_SET | addr;
         clns_pkg::CMD_CLEAR: begin
            cur_byte = clns_pkg::CLEAR_CODE;
            extra    = clear_wait_ff;
         end
         clns_pkg::CMD_INIT: begin
            cur_byte = clns_pkg::init_byte(cmd.byte_idx);
            if (cmd.byte_idx == clns_pkg::IDX_LAST) begin
               extra = clear_wait_ff;
            end else if (cmd.byte_idx != 2'd0) begin
               extra = setup_wait_ff;
            end
         end
         default: ;
      endcase
   end

   // phase bit 1 picks the nibble, bit 0 the enable level
   always_comb begin
      if (cmd.pwr) begin
         nibble_in = 4'd0;
         rs_in     = 1'b0;
         en_in     = 1'b0;
         hold_in   = {1'b0, powerup_ff};
      end else begin
         nibble_in = cmd.phase[1] ? cur_byte[3:0]
                                  : 4'((cur_byte & clns_pkg::NIBBLE_HI_MASK) >> 4);
         rs_in     = (cmd_ff == clns_pkg::CMD_DATA);
         en_in     = !cmd.phase[0];
         if (!cmd.phase[0]) begin
            hold_in = {9'd0, en_high_ff};
         end else if (cmd.phase == clns_pkg::PHASE_LAST) begin
            hold_in = {7'd0, en_low_ff} + {1'b0, extra};
         end else begin
            hold_in = {7'd0, en_low_ff};
         end
      end
      last_in = cmd.last;
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         nibble_ff <= nibble_in;
         rs_ff     <= rs_in;
         en_ff     <= en_in;
         hold_ff   <= hold_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_nibble     = nibble_ff;
   assign rsp_reg_select = rs_ff;
   assign rsp_enable     = en_ff;
   assign rsp_hold_us    = hold_ff;
   assign rsp_last       = last_ff;

endmodule

@@ sv/char_lcd_nibble_sequencer_top.sv @@
// Character LCD sequencer for a 4-bit parallel LCD bus.
// req channel: one request per transfer (cmd, value, row, col). Commands 0 to 3
// send one byte as four pin events (high nibble then low nibble, each with an
// enable-high and an enable-low event); command 4 sends a power-up wait event
// and then the bytes 0x02, 0x28, 0x0C and 0x01, seventeen events in all.
// Codes 5 to 7 are taken and produce nothing.
// rsp channel: one pin event per transfer (nibble, RS, EN, hold time in us);
// last marks the final event of a request.
// The request transfer moves the controller out of idle; its first event is then
// registered in the output register. Throughput: one event per cycle while rsp
// is not stalled; the controller handles one request at a time and holds
// req_stall high until its last event is registered. A rsp stall freezes the
// output register and the sequencer.
// csr port: write-only timing registers, 0 enable high, 1 enable low,
// 2 clear wait, 3 setup wait, 4 power-up wait; write only while idle.
// Reset (synchronous) restores the register defaults and empties the output.
module char_lcd_nibble_sequencer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [clns_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [clns_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_cmd,
   input  logic [7:0]                        req_value,
   input  logic [1:0]                        req_row,
   input  logic [5:0]                        req_col,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [3:0]                        rsp_nibble,
   output logic                              rsp_reg_select,
   output logic                              rsp_enable,
   output logic [clns_pkg::HOLD_W-1:0]       rsp_hold_us,
   output logic                              rsp_last
);

   clns_pkg::ctl_cmd_type ctl_cmd;
   clns_pkg::dp_sts_type  dp_sts;

   clns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .sts       (dp_sts),
      .cmd       (ctl_cmd)
   );

   clns_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_row        (req_row),
      .req_col        (req_col),
      .cmd            (ctl_cmd),
      .sts            (dp_sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_nibble     (rsp_nibble),
      .rsp_reg_select (rsp_reg_select),
      .rsp_enable     (rsp_enable),
      .rsp_hold_us    (rsp_hold_us),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   a_load_emit_excl: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.emit |-> !ctl_cmd.load)
      else $error("request load while events still in flight");

   a_next_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("gap inside a request's event stream");

   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd == clns_pkg::CMD_INIT) |=> req_stall)
      else $error("init request did not start the sequencer");

   a_last_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !rsp_enable)
      else $error("final event with enable high");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int IDLE_PERCENT = 10;
   localparam int HOLD_OFF_CYCLES = 300;

   localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
   localparam logic [2:0] CMD_RESERVED_HI = 3'd7;
   localparam logic [clns_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [3:0]                  nibble;
      logic                        reg_select;
      logic                        enable;
      logic [clns_pkg::HOLD_W-1:0] hold_us;
      logic                        last;
   } pin_event_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [clns_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [clns_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_cmd;
   logic [7:0] req_value;
   logic [1:0] req_row;
   logic [5:0] req_col;
   logic rsp_valid;
   logic rsp_stall;
   logic [3:0] rsp_nibble;
   logic rsp_reg_select;
   logic rsp_enable;
   logic [clns_pkg::HOLD_W-1:0] rsp_hold_us;
   logic rsp_last;

   pin_event_type pin_expect_q[$];

   logic [7:0]  t_en_high;
   logic [9:0]  t_en_low;
   logic [15:0] t_clear_wait;
   logic [15:0] t_setup_wait;
   logic [15:0] t_powerup_wait;

   int error_count = 0;
   int cycle_count = 0;
   int rsp_hold_left = 0;
   bit idle_off = 1'b0;

   char_lcd_nibble_sequencer_top DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_row        (req_row),
      .req_col        (req_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_nibble     (rsp_nibble),
      .rsp_reg_select (rsp_reg_select),
      .rsp_enable     (rsp_enable),
      .rsp_hold_us    (rsp_hold_us),
      .rsp_last       (rsp_last)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void queue_pin_event(logic [3:0] nib, logic rs, logic en,
                                           logic [clns_pkg::HOLD_W-1:0] hold);
      pin_event_type ev;
      ev.nibble = nib;
      ev.reg_select = rs;
      ev.enable = en;
      ev.hold_us = hold;
      ev.last = 1'b0;
      pin_expect_q.push_back(ev);
   endfunction

   // high nibble first, each nibble as enable-high then enable-low
   function automatic void queue_lcd_byte(logic [7:0] code, logic rs, logic [15:0] extra);
      logic [clns_pkg::HOLD_W-1:0] low_hold;
      low_hold = clns_pkg::HOLD_W'(t_en_low) + clns_pkg::HOLD_W'(extra);
      queue_pin_event(code[7:4], rs, 1'b1, clns_pkg::HOLD_W'(t_en_high));
      queue_pin_event(code[7:4], rs, 1'b0, clns_pkg::HOLD_W'(t_en_low));
      queue_pin_event(code[3:0], rs, 1'b1, clns_pkg::HOLD_W'(t_en_high));
      queue_pin_event(code[3:0], rs, 1'b0, low_hold);
   endfunction

   function automatic void predict_pin_events(logic [2:0] cmd, logic [7:0] value,
                                              logic [1:0] row, logic [5:0] col);
      logic [7:0] addr;
      pin_event_type tail;
      int depth;
      depth = pin_expect_q.size();
      case (cmd)
         clns_pkg::CMD_COMMAND: queue_lcd_byte(value, 1'b0, 16'd0);
         clns_pkg::CMD_DATA:    queue_lcd_byte(value, 1'b1, 16'd0);
         clns_pkg::CMD_CURSOR: begin
            addr = ((row == 2'd1) ? clns_pkg::ADDR_ROW1 : 8'h00) + {2'b00, col};
            queue_lcd_byte(clns_pkg::ADDR_SET | addr, 1'b0, 16'd0);
         end
         clns_pkg::CMD_CLEAR:   queue_lcd_byte(clns_pkg::CLEAR_CODE, 1'b0, t_clear_wait);
         clns_pkg::CMD_INIT: begin
            queue_pin_event(4'h0, 1'b0, 1'b0, clns_pkg::HOLD_W'(t_powerup_wait));
            queue_lcd_byte(clns_pkg::INIT_FOURBIT, 1'b0, 16'd0);
            queue_lcd_byte(clns_pkg::INIT_FUNCSET, 1'b0, t_setup_wait);
            queue_lcd_byte(clns_pkg::INIT_DISPON, 1'b0, t_setup_wait);
            queue_lcd_byte(clns_pkg::CLEAR_CODE, 1'b0, t_clear_wait);
         end
         default: ;
      endcase
      if (pin_expect_q.size() > depth) begin
         tail = pin_expect_q.pop_back();
         tail.last = 1'b1;
         pin_expect_q.push_back(tail);
      end
   endfunction

   function automatic void check_field(string name, logic [clns_pkg::HOLD_W-1:0] want,
                                       logic [clns_pkg::HOLD_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      pin_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pin_expect_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transfer, expected none actual nibble %0h hold %0d",
                     $time, rsp_nibble, rsp_hold_us);
         end else begin
            want = pin_expect_q.pop_front();
            check_field("nibble", clns_pkg::HOLD_W'(want.nibble),
                        clns_pkg::HOLD_W'(rsp_nibble));
            check_field("reg_select", clns_pkg::HOLD_W'(want.reg_select),
                        clns_pkg::HOLD_W'(rsp_reg_select));
            check_field("enable", clns_pkg::HOLD_W'(want.enable),
                        clns_pkg::HOLD_W'(rsp_enable));
            check_field("hold_us", want.hold_us, rsp_hold_us);
            check_field("last", clns_pkg::HOLD_W'(want.last), clns_pkg::HOLD_W'(rsp_last));
         end
      end
   end

   // receiver: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall = 1'b1;
         rsp_hold_left--;
      end else begin
         rsp_stall = !idle_off && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   task automatic send_req(logic [2:0] cmd, logic [7:0] value, logic [1:0] row,
                           logic [5:0] col);
      @(negedge clock);
      while (!idle_off && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_value = value;
      req_row = row;
      req_col = col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pin_events(cmd, value, row, col);
   endtask

   task automatic send_random_req(output bit counted);
      int pick;
      logic [2:0] cmd;
      pick = $urandom_range(0, 99);
      if (pick < 28) cmd = clns_pkg::CMD_COMMAND;
      else if (pick < 56) cmd = clns_pkg::CMD_DATA;
      else if (pick < 78) cmd = clns_pkg::CMD_CURSOR;
      else if (pick < 88) cmd = clns_pkg::CMD_CLEAR;
      else if (pick < 95) cmd = clns_pkg::CMD_INIT;
      else cmd = 3'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      counted = (pick < 95);
      send_req(cmd, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
               6'($urandom_range(0, 63)));
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      while (pin_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_timing(logic [clns_pkg::CSR_INDEX_W-1:0] idx,
                             logic [clns_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         clns_pkg::CSR_ENABLE_HIGH: t_en_high = data[7:0];
         clns_pkg::CSR_ENABLE_LOW:  t_en_low = data[9:0];
         clns_pkg::CSR_CLEAR_WAIT:  t_clear_wait = data;
         clns_pkg::CSR_SETUP_WAIT:  t_setup_wait = data;
         clns_pkg::CSR_POWERUP:     t_powerup_wait = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic load_timing(logic [15:0] en_high, logic [15:0] en_low,
                              logic [15:0] clear_wait, logic [15:0] setup_wait,
                              logic [15:0] powerup_wait);
      set_timing(clns_pkg::CSR_ENABLE_HIGH, en_high);
      set_timing(clns_pkg::CSR_ENABLE_LOW, en_low);
      set_timing(clns_pkg::CSR_CLEAR_WAIT, clear_wait);
      set_timing(clns_pkg::CSR_SETUP_WAIT, setup_wait);
      set_timing(clns_pkg::CSR_POWERUP, powerup_wait);
   endtask

   task automatic send_timing_mix();
      send_req(clns_pkg::CMD_INIT, 8'h00, 2'd0, 6'd0);
      send_req(clns_pkg::CMD_CLEAR, 8'h00, 2'd0, 6'd0);
      send_req(clns_pkg::CMD_CURSOR, 8'hFF, 2'd1, 6'd63);
   endtask

   task automatic test_directed_defaults();
      send_req(clns_pkg::CMD_INIT, 8'hFF, 2'd3, 6'd63);
      send_req(clns_pkg::CMD_COMMAND, 8'h00, 2'd0, 6'd0);
      send_req(clns_pkg::CMD_COMMAND, 8'hFF, 2'd3, 6'd63);
      send_req(clns_pkg::CMD_DATA, 8'hA5, 2'd2, 6'd21);
      send_req(clns_pkg::CMD_DATA, 8'h5A, 2'd1, 6'd42);
      send_req(clns_pkg::CMD_CURSOR, 8'hFF, 2'd0, 6'd0);
      send_req(clns_pkg::CMD_CURSOR, 8'h00, 2'd1, 6'd63);
      send_req(clns_pkg::CMD_CURSOR, 8'h00, 2'd2, 6'd63);
      send_req(clns_pkg::CMD_CURSOR, 8'h00, 2'd3, 6'd21);
      send_req(clns_pkg::CMD_CURSOR, 8'h00, 2'd1, 6'd0);
      send_req(clns_pkg::CMD_CLEAR, 8'hFF, 2'd3, 6'd63);
      send_req(CMD_RESERVED_LO, 8'h12, 2'd1, 6'd5);
      send_req(CMD_RESERVED_HI, 8'hFF, 2'd3, 6'd63);
      wait_quiet();
   endtask

   task automatic test_timing_extremes();
      load_timing(16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
      send_timing_mix();
      wait_quiet();
      load_timing(16'd255, 16'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_timing_mix();
      wait_quiet();
      // zero holds, unused index and out-of-width data bits
      load_timing(16'd0, 16'd0, 16'd7, 16'd3, 16'd1);
      set_timing(CSR_UNUSED, 16'hFFFF);
      send_req(clns_pkg::CMD_DATA, 8'hC3, 2'd0, 6'd0);
      send_req(clns_pkg::CMD_INIT, 8'h00, 2'd0, 6'd0);
      wait_quiet();
      set_timing(clns_pkg::CSR_ENABLE_HIGH, 16'hFF80);
      set_timing(clns_pkg::CSR_ENABLE_LOW, 16'hFC00);
      send_req(clns_pkg::CMD_CLEAR, 8'h3C, 2'd2, 6'd33);
      wait_quiet();
   endtask

   task automatic test_random_traffic(int phases, int per_phase);
      int sent;
      bit counted;
      for (int p = 0; p < phases; p++) begin
         if (p == 0)
            load_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
         else
            load_timing(16'($urandom_range(1, 255)), 16'($urandom_range(1, 1023)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
         idle_off = (p == 1);
         sent = 0;
         while (sent < per_phase) begin
            send_random_req(counted);
            if (counted) sent++;
         end
         idle_off = 1'b0;
         wait_quiet();
      end
   endtask

   task automatic test_output_backpressure();
      bit counted;
      rsp_hold_left = HOLD_OFF_CYCLES;
      idle_off = 1'b1;
      for (int i = 0; i < 10; i++) send_random_req(counted);
      idle_off = 1'b0;
      wait_quiet();
   endtask

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = clns_pkg::CSR_ENABLE_HIGH;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_cmd = clns_pkg::CMD_COMMAND;
      req_value = 8'h00;
      req_row = 2'd0;
      req_col = 6'd0;
      rsp_stall = 1'b0;
      t_en_high = clns_pkg::ENABLE_HIGH_RST;
      t_en_low = clns_pkg::ENABLE_LOW_RST;
      t_clear_wait = clns_pkg::CLEAR_WAIT_RST;
      t_setup_wait = clns_pkg::SETUP_WAIT_RST;
      t_powerup_wait = clns_pkg::POWERUP_RST;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_defaults();
      test_timing_extremes();
      test_random_traffic(5, 56);
      test_output_backpressure();

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/clns_pkg.sv
sv/clns_ctrl.sv
sv/clns_dp.sv
sv/char_lcd_nibble_sequencer_top.sv
tb/testbench.sv
